// ===== hw/rtl/a0fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// a0fcd_pkg
// Shared types and constants for the A0 frame checker / deframer.
// ----------------------------------------------------------------------------
package a0fcd_pkg;

  localparam int unsigned CountW = 17;

  localparam logic [7:0]        TYPE_A0     = 8'hA0;
  localparam logic [7:0]        CSUM_BASE   = 8'hAA;
  localparam logic [CountW:0]   MIN_FRAME   = 18'd8;
  localparam logic [CountW:0]   OUTER_EXTRA = 18'd4;
  localparam logic [15:0]       OUTER_MIN   = 16'd4;
  localparam logic [16:0]       INNER_EXTRA = 17'd3;
  localparam logic [CountW-1:0] COUNT_MAX   = {CountW{1'b1}};

  // header offsets
  localparam logic [CountW-1:0] OFS_TYPE    = 17'd0;
  localparam logic [CountW-1:0] OFS_LEN_LO  = 17'd1;
  localparam logic [CountW-1:0] OFS_LEN_HI  = 17'd2;
  localparam logic [CountW-1:0] OFS_TAG     = 17'd3;
  localparam logic [CountW-1:0] OFS_CTRL    = 17'd4;
  localparam logic [CountW-1:0] OFS_INR_LO  = 17'd5;
  localparam logic [CountW-1:0] OFS_INR_HI  = 17'd6;
  localparam logic [CountW-1:0] OFS_BODY    = 17'd7;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_TAG  = 2'd2,
    ST_CSUM = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BODY   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic    valid;
    kind_t   kind;
    logic [7:0] body;
    logic [7:0] ctrl;
    status_t status;
    logic    done;
  } res_t;

endpackage

// ===== hw/rtl/a0_frame_checker_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// a0_frame_checker_deframer_unit
// Checks A0 frames byte by byte, passes body bytes out, ends with a status.
// ----------------------------------------------------------------------------
// Path: input register, then result register. Throughput: one byte per cycle
// while out_tready does not stall the result register, set by the single-step
// frame state update between the two registers.
// Reset (rst_n low, synchronous): both stages empty, frame state cleared,
// checksum seed 0.
module a0_frame_checker_deframer_unit
  import a0fcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // checksum_seed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  input  logic        in_tlast,      // end_of_transfer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [7:0] body_byte, [15:8] wire_control_byte,
                                     // [17:16] frame_status, [23:18] zero
  output logic        out_tuser,     // result_kind
  output logic        out_tlast      // frame_done
);

  logic       seed_r;
  logic [7:0] seed_val_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       core_res;
  logic       step;

  assign step      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= 1'b0;
      seed_val_r <= '0;
    end else if (cfg_we) begin
      seed_r     <= 1'b1;
      seed_val_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  a0fcd_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .rx_last (s1_last_r),
    .seed    (seed_r ? seed_val_r : 8'd0),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= core_res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.ctrl, out_res_r.body};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.done;

endmodule

// ===== hw/rtl/a0fcd_check.sv =====
// ----------------------------------------------------------------------------
// a0fcd_check
// Frame state, header capture and end-of-frame checks for one byte per step.
// ----------------------------------------------------------------------------
module a0fcd_check
  import a0fcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  input  logic [7:0] seed,
  output res_t       res
);

  logic [CountW-1:0] count_r, count_nxt;
  logic              type_ok_r, type_ok_nxt;
  logic [15:0]       outer_r, outer_nxt;
  logic              tag_ok_r, tag_ok_nxt;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [15:0]       inner_r, inner_nxt;
  logic [7:0]        sum_r, sum_nxt;

  logic [CountW:0]   len;
  logic [7:0]        expect_cs;
  logic [7:0]        tag_calc;
  logic              in_body;
  status_t           status;

  assign len       = {1'b0, count_r} + 18'd1;
  assign expect_cs = CSUM_BASE - (seed + inner_r[7:0] + sum_r);
  assign tag_calc  = TYPE_A0 + outer_r[7:0] + outer_r[15:8];
  assign in_body   = (count_r >= OFS_BODY);

  always_comb begin
    if (len < MIN_FRAME || !type_ok_r) begin
      status = ST_LEN;
    end else if (({2'b00, outer_r} + OUTER_EXTRA) != len || outer_r < OUTER_MIN) begin
      status = ST_LEN;
    end else if (!tag_ok_r) begin
      status = ST_TAG;
    end else if (inner_r == 16'd0 || ({1'b0, inner_r} + INNER_EXTRA) != {1'b0, outer_r}) begin
      status = ST_LEN;
    end else if (rx_byte != expect_cs) begin
      status = ST_CSUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res.valid  = rx_last || in_body;
    res.kind   = rx_last ? KIND_STATUS : KIND_BODY;
    res.body   = rx_last ? 8'd0 : rx_byte;
    res.ctrl   = (!rx_last || status == ST_OK) ? ctrl_r : 8'd0;
    res.status = rx_last ? status : ST_OK;
    res.done   = rx_last;
  end

  always_comb begin
    count_nxt   = count_r;
    type_ok_nxt = type_ok_r;
    outer_nxt   = outer_r;
    tag_ok_nxt  = tag_ok_r;
    ctrl_nxt    = ctrl_r;
    inner_nxt   = inner_r;
    sum_nxt     = sum_r;
    if (rx_last) begin
      count_nxt   = '0;
      type_ok_nxt = 1'b0;
      outer_nxt   = '0;
      tag_ok_nxt  = 1'b0;
      ctrl_nxt    = '0;
      inner_nxt   = '0;
      sum_nxt     = '0;
    end else begin
      case (count_r)
        OFS_TYPE:   type_ok_nxt = (rx_byte == TYPE_A0);
        OFS_LEN_LO: outer_nxt   = {outer_r[15:8], rx_byte};
        OFS_LEN_HI: outer_nxt   = {rx_byte, outer_r[7:0]};
        OFS_TAG:    tag_ok_nxt  = (rx_byte == tag_calc);
        OFS_CTRL:   ctrl_nxt    = rx_byte;
        OFS_INR_LO: inner_nxt   = {inner_r[15:8], rx_byte};
        OFS_INR_HI: inner_nxt   = {rx_byte, inner_r[7:0]};
        default:    ;
      endcase
      if (in_body) begin
        sum_nxt = sum_r + rx_byte;
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      type_ok_r <= 1'b0;
      outer_r   <= '0;
      tag_ok_r  <= 1'b0;
      ctrl_r    <= '0;
      inner_r   <= '0;
      sum_r     <= '0;
    end else if (step) begin
      count_r   <= count_nxt;
      type_ok_r <= type_ok_nxt;
      outer_r   <= outer_nxt;
      tag_ok_r  <= tag_ok_nxt;
      ctrl_r    <= ctrl_nxt;
      inner_r   <= inner_nxt;
      sum_r     <= sum_nxt;
    end
  end

endmodule

// ===== sim/a0_frame_checker_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// a0_frame_checker_deframer_unit_tb
// Self-checking bench for the A0 frame checker / deframer. A directed table of
// short frames covers the status codes, then random well-formed and corrupted
// frames run at several checksum seeds. Every output transfer is compared
// with a bit-accurate frame predictor, with random stalls on both streams.
// ----------------------------------------------------------------------------
module a0_frame_checker_deframer_unit_tb;
  import a0fcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body;
    logic [7:0] ctrl;
    status_t    status;
    logic       done;
  } frame_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] ctrl;
    status_t    status;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  a0_frame_checker_deframer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predictor state
  logic [7:0]  seed;
  logic [16:0] rx_count;
  logic        type_ok;
  logic [15:0] outer_len;
  logic        tag_ok;
  logic [7:0]  ctrl_hold;
  logic [15:0] inner_len;
  logic [7:0]  body_sum;

  frame_result_t expected_results[$];
  frame_result_t want;
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  bit          stall_on = 1'b1;
  stim_row_t   dir_rows [25];

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic clear_frame();
    rx_count  = '0;
    type_ok   = 1'b0;
    outer_len = '0;
    tag_ok    = 1'b0;
    ctrl_hold = '0;
    inner_len = '0;
    body_sum  = '0;
  endtask

  function automatic status_t frame_status(input logic [7:0] last_byte);
    logic [17:0] len;
    logic [7:0]  csum;
    len  = {1'b0, rx_count} + 18'd1;
    csum = CSUM_BASE - (seed + inner_len[7:0] + body_sum);
    if (len < MIN_FRAME || !type_ok) return ST_LEN;
    if ({2'b00, outer_len} + 18'd4 != len || outer_len < 16'd4) return ST_LEN;
    if (!tag_ok) return ST_TAG;
    if (inner_len == 16'd0 || {1'b0, inner_len} + 17'd3 != {1'b0, outer_len}) return ST_LEN;
    if (last_byte != csum) return ST_CSUM;
    return ST_OK;
  endfunction

  task automatic advance_frame(input logic [7:0] b, input logic last,
                               output bit has, output frame_result_t res);
    status_t st;
    has = 1'b0;
    res = '0;
    if (last) begin
      st = frame_status(b);
      res = '{KIND_STATUS, 8'h00, (st == ST_OK) ? ctrl_hold : 8'h00, st, 1'b1};
      has = 1'b1;
      clear_frame();
    end else begin
      case (rx_count)
        OFS_TYPE:   type_ok = (b == TYPE_A0);
        OFS_LEN_LO: outer_len[7:0] = b;
        OFS_LEN_HI: outer_len[15:8] = b;
        OFS_TAG:    tag_ok = (b == 8'(TYPE_A0 + outer_len[7:0] + outer_len[15:8]));
        OFS_CTRL:   ctrl_hold = b;
        OFS_INR_LO: inner_len[7:0] = b;
        OFS_INR_HI: inner_len[15:8] = b;
        default: ;
      endcase
      if (rx_count >= OFS_BODY) begin
        body_sum = body_sum + b;
        if (rx_count != COUNT_MAX) rx_count = rx_count + 17'd1;
        res = '{KIND_BODY, b, ctrl_hold, ST_OK, 1'b0};
        has = 1'b1;
      end else begin
        rx_count = rx_count + 17'd1;
      end
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input frame_result_t typed_res);
    int            gap;
    bit            has;
    frame_result_t res;
    gap = stall_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    advance_frame(b, last, has, res);
    if (has) expected_results.push_back(typed ? typed_res : res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_seed(input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    seed = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random_frame();
    int          n, mode, len, i;
    logic [15:0] outer, inner;
    logic [7:0]  tag, ctrl, sum, csum, tbyte, b;
    logic [7:0]  fq[$];
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
    mode = $urandom_range(0, 15);
    if (mode == 14) begin
      // truncated header
      len = $urandom_range(1, 7);
      for (i = 0; i < len; i++)
        fq.push_back((i == 0 && $urandom_range(0, 1)) ? TYPE_A0 : 8'($urandom_range(0, 255)));
    end else if (mode == 15) begin
      len = $urandom_range(8, 24);
      for (i = 0; i < len; i++) fq.push_back(8'($urandom_range(0, 255)));
    end else begin
      outer = 16'(n + 4);
      inner = 16'(n + 1);
      if (mode == 9) outer = outer ^ 16'($urandom_range(1, 65535));
      if (mode == 11) inner = $urandom_range(0, 1) ? 16'd0 : inner ^ 16'($urandom_range(1, 65535));
      tag = TYPE_A0 + outer[7:0] + outer[15:8];
      if (mode == 10) tag = tag ^ 8'($urandom_range(1, 255));
      tbyte = TYPE_A0;
      if (mode == 8) begin
        tbyte = 8'($urandom_range(0, 255));
        if (tbyte == TYPE_A0) tbyte = ~tbyte;
      end
      ctrl = 8'($urandom_range(0, 255));
      fq = '{tbyte, outer[7:0], outer[15:8], tag, ctrl, inner[7:0], inner[15:8]};
      sum = 8'h00;
      for (i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        sum = sum + b;
        fq.push_back(b);
      end
      csum = CSUM_BASE - (seed + inner[7:0] + sum);
      if (mode == 12) csum = csum ^ 8'($urandom_range(1, 255));
      fq.push_back(csum);
    end
    for (i = 0; i < fq.size(); i++) send_byte(fq[i], i == fq.size() - 1, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with nothing expected, actual tdata %h tuser %b tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_tuser);
        check_field("body_byte", want.body, out_tdata[7:0]);
        check_field("wire_control_byte", want.ctrl, out_tdata[15:8]);
        check_field("frame_status", want.status, out_tdata[17:16]);
        check_field("frame_done", want.done, out_tlast);
      end
    end
  end

  // result side back-pressure
  initial begin
    int k;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      k = stall_on ? $urandom_range(0, 7) : 0;
      if (k > 0) begin
        out_tready = 1'b0;
        repeat (k) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int            r, p, target;
    frame_result_t typed_res;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    seed      = 8'h00;
    clear_frame();

    dir_rows = '{
      '{8'hFF, 1'b1, 1'b1, 8'h00, ST_LEN},
      '{8'hA0, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h04, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hA4, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h01, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hA9, 1'b1, 1'b1, 8'hFF, ST_OK},
      '{8'hA0, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h04, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h5B, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h01, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hA9, 1'b1, 1'b1, 8'h00, ST_TAG},
      '{8'hA0, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h04, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'hA4, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h01, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b0, 1'b0, 8'h00, ST_OK},
      '{8'h00, 1'b1, 1'b1, 8'h00, ST_CSUM}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, seed at its reset value
    for (r = 0; r < 25; r++) begin
      typed_res = '{KIND_STATUS, 8'h00, dir_rows[r].ctrl, dir_rows[r].status, 1'b1};
      send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed, typed_res);
    end
    drain();

    for (p = 0; p < 4; p++) begin
      case (p)
        0: write_seed(8'hFF);
        1: write_seed(8'h00);
        default: write_seed(8'($urandom_range(0, 255)));
      endcase
      target = bytes_sent + 400;
      while (bytes_sent < target) begin
        stall_on = ($urandom_range(0, 3) != 0);
        send_random_frame();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/a0fcd_pkg.sv
hw/rtl/a0fcd_check.sv
hw/rtl/a0_frame_checker_deframer_unit.sv
sim/a0_frame_checker_deframer_unit_tb.sv
